// ===== hw/rtl/pa_pkg.sv =====
// Shared types and constants for the primitive assembler.
`timescale 1ns / 1ps

package pa_pkg;

    typedef enum logic [2:0] {
        PK_TRIS   = 3'd0,
        PK_STRIP  = 3'd1,
        PK_FAN    = 3'd2,
        PK_QUADS  = 3'd3,
        PK_LINES  = 3'd4,
        PK_LSTRIP = 3'd5,
        PK_POINTS = 3'd6,
        PK_NONE   = 3'd7
    } prim_kind_t;

    typedef enum logic [1:0] {
        SK_TRI   = 2'd0,
        SK_LINE  = 2'd1,
        SK_POINT = 2'd2
    } shape_kind_t;

    // Header of one queued job; pair marks a quad that yields two triangles.
    typedef struct packed {
        shape_kind_t kind;
        logic        pair;
    } job_hdr_t;

    localparam int HDR_BITS     = $bits(job_hdr_t);
    localparam int OUT_TAG_BITS = 16;
    localparam int QUEUE_DEPTH  = 4;

endpackage

// ===== hw/rtl/primitive_assembler.sv =====
// Top level of the primitive assembler: front end, job queue, back end.
`timescale 1ns / 1ps
//
// Builds triangles, lines and points from a stream of vertex tags.
// Input channel s_*: one vertex per transfer, tag in s_tdata, primitive
// kind and batch start flag in s_tuser. Output channel m_*: one shape per
// transfer, kind and three corners in m_tdata, m_tlast set on the last
// shape caused by a vertex.
// The completing vertex is written into the job queue, the back end then
// loads that job from the queue into its output register, and m_tvalid is
// high once the job is loaded.
// Throughput: one vertex per cycle; a completed quad yields two triangles
// that go out one after the other, the extra one soaked up by the 4-entry job
// queue. s_tready drops only when that queue is full.
// Vertices that complete no shape just update the group state.
// Reset clears the group counters and empties the queue; saved tags are
// undefined until a batch writes them.
// When the receiver stalls, the current shape holds on m_tdata, the queue
// fills, and then s_tready goes low.
//
module primitive_assembler #(
    parameter int TAG_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] vertex_tag
    input  logic [3:0]  s_tuser,   // [2:0] prim_kind, [3] batch_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [1:0] shape_kind, [17:2] corner_a,
                                   // [33:18] corner_b, [49:34] corner_c
    output logic        m_tlast    // last_of_run
);
    import pa_pkg::*;

    localparam int TW = (TAG_BITS < OUT_TAG_BITS) ? TAG_BITS : OUT_TAG_BITS;
    localparam int JW = HDR_BITS + 4*TW;

    logic          push;
    logic [JW-1:0] push_job;
    logic          q_full;
    logic          q_nonempty;
    logic          q_pop;
    logic [JW-1:0] q_job;

    pa_front #(
        .TW (TW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .vertex_tag  (s_tdata[TW-1:0]),
        .prim_kind   (prim_kind_t'(s_tuser[2:0])),
        .batch_start (s_tuser[3]),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    pa_queue #(
        .WIDTH (JW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (q_full),
        .nonempty  (q_nonempty),
        .pop       (q_pop),
        .pop_data  (q_job)
    );

    pa_back #(
        .TW (TW)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_job      (q_job),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== hw/rtl/pa_front.sv =====
// Front end: takes vertices, tracks group state and builds shape jobs.
`timescale 1ns / 1ps

module pa_front #(
    parameter int TW = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [TW-1:0]                   vertex_tag,
    input  pa_pkg::prim_kind_t              prim_kind,
    input  logic                            batch_start,
    input  logic                            q_full,
    output logic                            push,
    output logic [pa_pkg::HDR_BITS+4*TW-1:0] push_job
);
    import pa_pkg::*;

    logic [TW-1:0] anchor_reg, anchor_next;
    logic [TW-1:0] older_reg, older_next;
    logic [TW-1:0] newer_reg, newer_next;
    logic [1:0]    phase_reg, phase_next;
    logic          hist_reg, hist_next;
    logic          parity_reg, parity_next;

    logic [1:0]    ph;
    logic          hf;
    logic          par;
    logic          emit;
    job_hdr_t      hdr;
    logic [TW-1:0] ja, jb, jc, jd;
    logic          take;

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        // batch start clears the group state before this tag is used
        ph  = batch_start ? 2'd0 : phase_reg;
        hf  = batch_start ? 1'b0 : hist_reg;
        par = batch_start ? 1'b0 : parity_reg;

        anchor_next = anchor_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;
        phase_next  = ph;
        hist_next   = hf;
        parity_next = par;
        emit        = 1'b0;
        hdr.kind    = SK_TRI;
        hdr.pair    = 1'b0;
        ja          = '0;
        jb          = '0;
        jc          = '0;
        jd          = '0;

        case (prim_kind)
            PK_TRIS:
            begin
                if (ph == 2'd0)
                begin
                    older_next = vertex_tag;
                    phase_next = 2'd1;
                end
                else if (ph == 2'd1)
                begin
                    newer_next = vertex_tag;
                    phase_next = 2'd2;
                end
                else
                begin
                    emit       = 1'b1;
                    ja         = older_reg;
                    jb         = newer_reg;
                    jc         = vertex_tag;
                    phase_next = 2'd0;
                end
            end
            PK_STRIP:
            begin
                if (ph == 2'd0)
                begin
                    older_next = vertex_tag;
                    phase_next = 2'd1;
                end
                else if (ph == 2'd1)
                begin
                    newer_next = vertex_tag;
                    phase_next = 2'd2;
                end
                else
                begin
                    emit        = 1'b1;
                    // odd triangles swap the first two corners
                    ja          = par ? newer_reg : older_reg;
                    jb          = par ? older_reg : newer_reg;
                    jc          = vertex_tag;
                    older_next  = newer_reg;
                    newer_next  = vertex_tag;
                    parity_next = !par;
                    phase_next  = 2'd2;
                end
            end
            PK_FAN:
            begin
                if (ph == 2'd0)
                begin
                    anchor_next = vertex_tag;
                    phase_next  = 2'd1;
                end
                else if (ph == 2'd1)
                begin
                    newer_next = vertex_tag;
                    phase_next = 2'd2;
                end
                else
                begin
                    emit       = 1'b1;
                    ja         = anchor_reg;
                    jb         = newer_reg;
                    jc         = vertex_tag;
                    newer_next = vertex_tag;
                    phase_next = 2'd2;
                end
            end
            PK_QUADS:
            begin
                if (ph == 2'd0)
                begin
                    anchor_next = vertex_tag;
                    phase_next  = 2'd1;
                end
                else if (ph == 2'd1)
                begin
                    older_next = vertex_tag;
                    phase_next = 2'd2;
                end
                else if (ph == 2'd2)
                begin
                    newer_next = vertex_tag;
                    phase_next = 2'd3;
                end
                else
                begin
                    // back end sends (a,b,c) then (a,c,d)
                    emit       = 1'b1;
                    hdr.pair   = 1'b1;
                    ja         = anchor_reg;
                    jb         = older_reg;
                    jc         = newer_reg;
                    jd         = vertex_tag;
                    phase_next = 2'd0;
                end
            end
            PK_LINES:
            begin
                if (ph == 2'd0)
                begin
                    older_next = vertex_tag;
                    phase_next = 2'd1;
                end
                else
                begin
                    emit       = 1'b1;
                    hdr.kind   = SK_LINE;
                    ja         = older_reg;
                    jb         = vertex_tag;
                    phase_next = 2'd0;
                end
            end
            PK_LSTRIP:
            begin
                emit       = hf;
                hdr.kind   = SK_LINE;
                ja         = newer_reg;
                jb         = vertex_tag;
                newer_next = vertex_tag;
                hist_next  = 1'b1;
            end
            PK_POINTS:
            begin
                emit     = 1'b1;
                hdr.kind = SK_POINT;
                ja       = vertex_tag;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    assign push     = take && emit;
    assign push_job = {hdr, ja, jb, jc, jd};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= 2'd0;
            hist_reg   <= 1'b0;
            parity_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            hist_reg   <= hist_next;
            parity_reg <= parity_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            anchor_reg <= anchor_next;
            older_reg  <= older_next;
            newer_reg  <= newer_next;
        end
    end

endmodule

// ===== hw/rtl/pa_queue.sv =====
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module pa_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             nonempty,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);
    import pa_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] slots [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [PW:0]      count_reg, count_next;

    assign full     = (count_reg == (PW+1)'(QUEUE_DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !nonempty))
        else $error("queue pop while empty");

endmodule

// ===== hw/rtl/pa_back.sv =====
// Back end: holds one job and sends its one or two shapes downstream.
`timescale 1ns / 1ps

module pa_back #(
    parameter int TW = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_nonempty,
    input  logic [pa_pkg::HDR_BITS+4*TW-1:0] q_job,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [55:0]                      m_tdata,
    output logic                             m_tlast
);
    import pa_pkg::*;

    localparam int JW = HDR_BITS + 4*TW;

    logic [JW-1:0] job_reg;
    logic          valid_reg, valid_next;
    logic          second_reg, second_next;
    logic          load;

    job_hdr_t      hdr;
    logic [TW-1:0] ta, tb, tc, td;
    logic [TW-1:0] ob, oc;
    logic          last;
    logic          sent;

    assign hdr = job_reg[JW-1 -: HDR_BITS];
    assign ta  = job_reg[4*TW-1 -: TW];
    assign tb  = job_reg[3*TW-1 -: TW];
    assign tc  = job_reg[2*TW-1 -: TW];
    assign td  = job_reg[TW-1:0];

    // second triangle of a quad is (a,c,d)
    assign ob   = second_reg ? tc : tb;
    assign oc   = second_reg ? td : tc;
    assign last = !hdr.pair || second_reg;
    assign sent = valid_reg && m_tready;

    assign q_pop = q_nonempty && (!valid_reg || (sent && last));
    assign load  = q_pop;

    always_comb
    begin
        valid_next  = valid_reg;
        second_next = second_reg;
        if (sent && !last)
        begin
            second_next = 1'b1;
        end
        else if (load)
        begin
            valid_next  = 1'b1;
            second_next = 1'b0;
        end
        else if (sent)
        begin
            valid_next  = 1'b0;
            second_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            second_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= q_job;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tlast  = last;
    assign m_tdata  = {6'b0, OUT_TAG_BITS'(oc), OUT_TAG_BITS'(ob), OUT_TAG_BITS'(ta),
                       hdr.kind};

    a_second_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (valid_reg && hdr.pair))
        else $error("second shape without a quad job");

    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        (sent && !last) |=> (valid_reg && second_reg))
        else $error("quad lost its second triangle");

endmodule
